[rtl/core/sicd_pkg.sv]
// ----------------------------------------------------------------------------
// sicd_pkg: shared types and constants for the decimal text converter
// Character codes, digit width and the control word that the digit cells share.
// ----------------------------------------------------------------------------
package sicd_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_BITS     = 4;
	localparam int CHAR_BITS      = 7;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;

	// Control word broadcast to every digit cell.
	typedef struct packed {
		logic clear;    // load zero into the digit
		logic convert;  // one double-dabble step: adjust, then shift in a bit
		logic shift;    // take the lower neighbour's digit (text read-out)
	} cell_ctrl_t;

endpackage

[rtl/core/sicd_value_if.sv]
// ----------------------------------------------------------------------------
// sicd_value_if: input channel carrying one signed integer per beat
// Valid/ready handshake; a beat moves when both are high at a rising edge.
// ----------------------------------------------------------------------------
interface sicd_value_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/sicd_char_if.sv]
// ----------------------------------------------------------------------------
// sicd_char_if: output channel carrying one ASCII character per beat
// Valid/ready handshake; last marks the final character of a number's text.
// ----------------------------------------------------------------------------
interface sicd_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;
	logic       last;

	modport source (output valid, output ascii_char, output last, input ready);
	modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

[rtl/core/sicd_digit_cell.sv]
// ----------------------------------------------------------------------------
// sicd_digit_cell: one BCD digit of the double-dabble chain
// Adds three to a digit of five or more and shifts in the neighbour's carry;
// during read-out it takes the lower neighbour's digit instead.
// ----------------------------------------------------------------------------
module sicd_digit_cell
	import sicd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic                  carry_in,
	input  logic [DIGIT_BITS-1:0] digit_in,
	output logic [DIGIT_BITS-1:0] digit,
	output logic                  carry_out
);

	logic [DIGIT_BITS-1:0] digit_q;
	logic [DIGIT_BITS-1:0] adj;

	// The adjustment keeps the shifted digit a valid decimal digit.
	assign adj       = (digit_q >= DIGIT_BITS'(5)) ? digit_q + DIGIT_BITS'(3) : digit_q;
	assign carry_out = adj[DIGIT_BITS-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.convert) begin
			digit_q <= {adj[DIGIT_BITS-2:0], carry_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's-complement number to its decimal characters, sign first.
// ----------------------------------------------------------------------------
// The block takes one signed VALUE_BITS-bit number per input beat and sends its
// decimal text as one ASCII character per output beat, most significant digit
// first, with a leading '-' for a negative number and no leading zeros; zero
// gives a single '0' and last is set on the final character of each number.
// The most negative value converts correctly, as the magnitude is formed
// unsigned. Conversion runs through a chain of BCD digit cells, one bit of the
// magnitude per cycle until all VALUE_BITS bits are in; then the sign is sent
// if the number is negative, the leading zeros are dropped by shifting the
// digits up the cell row, and the remaining digits are loaded into the output
// register one by one as the output side takes them. One number is handled at
// a time; the next input beat is taken once the final character has been
// loaded into the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
	import sicd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	sicd_value_if.sink  number,
	sicd_char_if.source text
);

	// Decimal digits needed for 2^(VALUE_BITS-1); 1233/4096 approximates log10(2).
	localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);
	localparam int CNT_BITS   = $clog2(VALUE_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_SKIP = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [CNT_BITS-1:0]   bit_cnt_q;
	logic [REM_BITS-1:0]   rem_q;

	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  out_char_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  out_free;
	logic                  top_zero;
	logic                  skip_step;
	logic                  emit_step;
	logic [VALUE_BITS-1:0] raw;
	cell_ctrl_t            ctrl;

	logic [DIGIT_BITS-1:0] cell_digit [NUM_DIGITS];
	logic                  cell_carry [NUM_DIGITS];

	assign raw          = VALUE_BITS'(number.value);
	assign number.ready = (state_q == ST_IDLE);
	assign accept       = number.valid && number.ready;

	// The output register is free when empty or when its beat leaves this cycle.
	assign out_free  = !out_valid_q || text.ready;
	assign top_zero  = (cell_digit[NUM_DIGITS-1] == '0);
	assign skip_step = (state_q == ST_SKIP) && top_zero && (rem_q > REM_BITS'(1));
	assign emit_step = (state_q == ST_EMIT) && out_free;

	// Every cell sees the same control word; data moves only between neighbours.
	always_comb begin
		ctrl.clear   = accept;
		ctrl.convert = (state_q == ST_CONV);
		ctrl.shift   = skip_step || emit_step;
	end

	// Row of digit cells, cell 0 least significant. During conversion the
	// magnitude enters at cell 0 MSB first and carries ripple upward; during
	// read-out each digit moves one cell up and the top cell is the one sent.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic                  c_in;
		logic [DIGIT_BITS-1:0] d_in;

		if (i == 0) begin : g_first
			assign c_in = mag_q[VALUE_BITS-1];
			assign d_in = '0;
		end else begin : g_next
			assign c_in = cell_carry[i-1];
			assign d_in = cell_digit[i-1];
		end

		sicd_digit_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.carry_in  (c_in),
			.digit_in  (d_in),
			.digit     (cell_digit[i]),
			.carry_out (cell_carry[i])
		);
	end

	// Sequencer: load, convert bit by bit, send the sign, drop leading zeros,
	// then send the remaining digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			rem_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= raw[VALUE_BITS-1];
						bit_cnt_q <= CNT_BITS'(VALUE_BITS - 1);
						rem_q     <= REM_BITS'(NUM_DIGITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_BITS'(1);
					if (bit_cnt_q == '0) begin
						state_q <= neg_q ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_step) begin
						rem_q <= rem_q - REM_BITS'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_step) begin
						rem_q <= rem_q - REM_BITS'(1);
						if (rem_q == REM_BITS'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Magnitude shift register; the most negative value negates to itself,
	// which read unsigned is the right magnitude.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Output register between the cell row and the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_SIGN && out_free) || emit_step) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN && out_free) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (emit_step) begin
			out_char_q <= CHAR_ZERO + CHAR_BITS'(cell_digit[NUM_DIGITS-1]);
			out_last_q <= (rem_q == REM_BITS'(1));
		end
	end

	assign text.valid      = out_valid_q;
	assign text.ascii_char = out_char_q;
	assign text.last       = out_last_q;

	// The top cell always holds a decimal digit.
	a_top_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		cell_digit[NUM_DIGITS-1] <= DIGIT_BITS'(9))
		else $error("top digit cell holds a non-decimal value");

	// A character on the output is a minus sign or a decimal digit.
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q == CHAR_MINUS ||
			(out_char_q >= CHAR_ZERO && out_char_q <= CHAR_ZERO + CHAR_BITS'(9))))
		else $error("output character is neither a digit nor a minus sign");

	// Sending the final digit returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_step && rem_q == REM_BITS'(1)) |=> (state_q == ST_IDLE && out_last_q))
		else $error("block did not go idle after the final character");

	// A minus sign is never flagged as the last character.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_char_q == CHAR_MINUS) |-> !out_last_q)
		else $error("minus sign flagged as last character");

endmodule
